/* rtl/core/bounded_stack_sort_reverse_defines.svh */
// assertion macros for the bounded stack block
`ifndef BOUNDED_STACK_SORT_REVERSE_DEFINES_SVH
`define BOUNDED_STACK_SORT_REVERSE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge out of reset
`define BSSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bssr assertion failed");

// consequent checked in the cycle after the antecedent
`define BSSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bssr assertion failed");

`else

`define BSSR_ASSERT(lbl, clk, rst_n, prop)
`define BSSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/bssr_pkg.sv */
// shared types, constants and codes of the bounded stack block
`timescale 1ns / 1ps

package bssr_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 5;
  localparam int FILL_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd5;

  localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SHOW = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SORT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REV  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
    logic [FILL_W-1:0]        fill_count;
  } out_item_t;

  typedef enum logic [1:0] {
    WR_PUSH,
    WR_RD_A,
    WR_RD_B,
    WR_X
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic              in_load;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    wr_sel_t           wr_sel;
    logic              x_load;
    cnt_op_t           cnt_op;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
    logic              out_use_rd;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             out_free;
    logic             x_gt;
  } stat_t;

endpackage

/* rtl/core/bssr_datapath.sv */
// stack storage, count and capacity registers, compare and result register
`timescale 1ns / 1ps

`include "bounded_stack_sort_reverse_defines.svh"

module bssr_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bssr_pkg::CAP_W-1:0]      cfg_data,
  input  bssr_pkg::in_item_t              in_item,
  input  bssr_pkg::cmd_t                  cmd,
  output bssr_pkg::stat_t                 stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bssr_pkg::out_item_t             out_item
);

  logic [bssr_pkg::DATA_W-1:0] mem [bssr_pkg::DEPTH];

  logic [bssr_pkg::DATA_W-1:0] rd_a_r;
  logic [bssr_pkg::DATA_W-1:0] rd_b_r;
  logic [bssr_pkg::DATA_W-1:0] x_r;
  logic [bssr_pkg::DATA_W-1:0] val_r;
  logic [bssr_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bssr_pkg::CAP_W-1:0]  cap_r;
  logic                        out_valid_r, out_valid_nxt;
  bssr_pkg::out_item_t         out_item_r, out_item_nxt;
  logic [bssr_pkg::CNT_W-1:0]  cap_sat;
  logic [bssr_pkg::DATA_W-1:0] wr_data;
  logic                        out_free;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || out_ready;

  // capacity above the storage depth acts as the depth
  always_comb begin
    if (32'(cap_r) > bssr_pkg::DEPTH) begin
      cap_sat = bssr_pkg::CNT_W'(bssr_pkg::DEPTH);
    end else begin
      cap_sat = bssr_pkg::CNT_W'(cap_r);
    end
  end

  assign stat.count    = count_r;
  assign stat.full     = (count_r >= cap_sat);
  assign stat.out_free = out_free;
  assign stat.x_gt     = ($signed(x_r) > $signed(rd_b_r));

  always_comb begin
    case (cmd.wr_sel)
      bssr_pkg::WR_PUSH: wr_data = val_r;
      bssr_pkg::WR_RD_A: wr_data = rd_a_r;
      bssr_pkg::WR_RD_B: wr_data = rd_b_r;
      bssr_pkg::WR_X:    wr_data = x_r;
      default:           wr_data = val_r;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      bssr_pkg::CNT_INC: count_nxt = count_r + 1'b1;
      bssr_pkg::CNT_DEC: count_nxt = count_r - 1'b1;
      default:           count_nxt = count_r;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (cmd.out_load) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.status     = cmd.out_status;
      out_item_nxt.data       = cmd.out_use_rd ? rd_a_r : '0;
      out_item_nxt.last       = cmd.out_last;
      out_item_nxt.fill_count = bssr_pkg::FILL_W'(count_nxt);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= bssr_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (cmd.in_load) begin
      val_r <= in_item.push_value;
    end
    if (cmd.x_load) begin
      x_r <= rd_a_r;
    end
  end

  // two registered read ports, one write port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[cmd.rd_a_addr];
      rd_b_r <= mem[cmd.rd_b_addr];
    end
  end

  `BSSR_ASSERT(a_count_in_range, clk, rst_n, count_r <= bssr_pkg::CNT_W'(bssr_pkg::DEPTH))
  `BSSR_ASSERT(a_load_only_when_free, clk, rst_n, cmd.out_load |-> out_free)
  `BSSR_ASSERT_NEXT(a_push_grows, clk, rst_n, cmd.cnt_op == bssr_pkg::CNT_INC, count_r != '0)

endmodule

/* rtl/core/bssr_ctrl.sv */
// sequencer for push, pop, show, insertion sort and reverse
`timescale 1ns / 1ps

`include "bounded_stack_sort_reverse_defines.svh"

module bssr_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bssr_pkg::KIND_W-1:0] in_kind,
  input  bssr_pkg::stat_t             stat,
  output bssr_pkg::cmd_t              cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_POP_RD,
    S_POP_OUT,
    S_SHOW_RD,
    S_SHOW_OUT,
    S_SORT_FETCH,
    S_SORT_LOADX,
    S_SORT_STEP,
    S_REV_RD,
    S_REV_WA,
    S_REV_WB,
    S_RESULT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [bssr_pkg::ADDR_W-1:0] i_r, i_nxt;
  logic [bssr_pkg::ADDR_W-1:0] j_r, j_nxt;
  logic [bssr_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [bssr_pkg::CNT_W-1:0]  cnt_m1;
  logic [bssr_pkg::ADDR_W-1:0] cnt_top;
  logic                        cnt_zero;
  logic                        cnt_one;
  logic                        sort_more;
  logic                        rev_more;

  assign in_ready  = (state_r == S_IDLE);
  assign cnt_m1    = stat.count - 1'b1;
  assign cnt_top   = cnt_m1[bssr_pkg::ADDR_W-1:0];
  assign cnt_zero  = (stat.count == '0);
  assign cnt_one   = (stat.count == bssr_pkg::CNT_W'(1));
  assign sort_more = ((bssr_pkg::CNT_W'(i_r) + 1'b1) < stat.count);
  // i_r and j_r are the low and high ends of the pair being swapped
  assign rev_more  = ((bssr_pkg::CNT_W'(i_r) + 2'd2) < bssr_pkg::CNT_W'(j_r));

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    res_status_nxt = res_status_r;
    cmd            = '0;
    cmd.wr_sel     = bssr_pkg::WR_PUSH;
    cmd.cnt_op     = bssr_pkg::CNT_HOLD;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          unique case (in_kind)
            bssr_pkg::KIND_PUSH: begin
              state_nxt = S_PUSH;
            end
            bssr_pkg::KIND_POP: begin
              if (cnt_zero) begin
                res_status_nxt = bssr_pkg::STAT_EMPTY;
                state_nxt      = S_RESULT;
              end else begin
                state_nxt = S_POP_RD;
              end
            end
            bssr_pkg::KIND_SHOW: begin
              if (cnt_zero) begin
                res_status_nxt = bssr_pkg::STAT_EMPTY;
                state_nxt      = S_RESULT;
              end else begin
                i_nxt     = cnt_top;
                state_nxt = S_SHOW_RD;
              end
            end
            bssr_pkg::KIND_SORT: begin
              if (cnt_zero) begin
                res_status_nxt = bssr_pkg::STAT_EMPTY;
                state_nxt      = S_RESULT;
              end else if (cnt_one) begin
                res_status_nxt = bssr_pkg::STAT_OK;
                state_nxt      = S_RESULT;
              end else begin
                i_nxt     = bssr_pkg::ADDR_W'(1);
                state_nxt = S_SORT_FETCH;
              end
            end
            bssr_pkg::KIND_REV: begin
              if (cnt_zero) begin
                res_status_nxt = bssr_pkg::STAT_EMPTY;
                state_nxt      = S_RESULT;
              end else if (cnt_one) begin
                res_status_nxt = bssr_pkg::STAT_OK;
                state_nxt      = S_RESULT;
              end else begin
                i_nxt     = '0;
                j_nxt     = cnt_top;
                state_nxt = S_REV_RD;
              end
            end
            default: begin
              res_status_nxt = bssr_pkg::STAT_OK;
              state_nxt      = S_RESULT;
            end
          endcase
        end
      end

      S_PUSH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          if (stat.full) begin
            cmd.out_status = bssr_pkg::STAT_FULL;
          end else begin
            cmd.out_status = bssr_pkg::STAT_OK;
            cmd.wr_en      = 1'b1;
            cmd.wr_addr    = stat.count[bssr_pkg::ADDR_W-1:0];
            cmd.wr_sel     = bssr_pkg::WR_PUSH;
            cmd.cnt_op     = bssr_pkg::CNT_INC;
          end
          state_nxt = S_IDLE;
        end
      end

      S_POP_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_a_addr = cnt_top;
        state_nxt     = S_POP_OUT;
      end

      S_POP_OUT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = bssr_pkg::STAT_OK;
          cmd.out_use_rd = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.cnt_op     = bssr_pkg::CNT_DEC;
          state_nxt      = S_IDLE;
        end
      end

      S_SHOW_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_a_addr = i_r;
        state_nxt     = S_SHOW_OUT;
      end

      S_SHOW_OUT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = bssr_pkg::STAT_OK;
          cmd.out_use_rd = 1'b1;
          cmd.out_last   = (i_r == '0);
          if (i_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r - 1'b1;
            state_nxt = S_SHOW_RD;
          end
        end
      end

      // insertion sort: x is entry i, walked down while it beats the one below
      S_SORT_FETCH: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_a_addr = i_r;
        cmd.rd_b_addr = i_r - 1'b1;
        j_nxt         = i_r;
        state_nxt     = S_SORT_LOADX;
      end

      S_SORT_LOADX: begin
        cmd.x_load    = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_a_addr = i_r;
        cmd.rd_b_addr = i_r - 1'b1;
        state_nxt     = S_SORT_STEP;
      end

      S_SORT_STEP: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = j_r;
        if ((j_r != '0) && stat.x_gt) begin
          // shift the smaller neighbor up, fetch the next one below
          cmd.wr_sel    = bssr_pkg::WR_RD_B;
          cmd.rd_en     = 1'b1;
          cmd.rd_a_addr = i_r;
          cmd.rd_b_addr = j_r - 2'd2;
          j_nxt         = j_r - 1'b1;
        end else begin
          cmd.wr_sel = bssr_pkg::WR_X;
          if (sort_more) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_SORT_FETCH;
          end else begin
            res_status_nxt = bssr_pkg::STAT_OK;
            state_nxt      = S_RESULT;
          end
        end
      end

      S_REV_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_a_addr = i_r;
        cmd.rd_b_addr = j_r;
        state_nxt     = S_REV_WA;
      end

      S_REV_WA: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = i_r;
        cmd.wr_sel  = bssr_pkg::WR_RD_B;
        state_nxt   = S_REV_WB;
      end

      S_REV_WB: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = j_r;
        cmd.wr_sel  = bssr_pkg::WR_RD_A;
        if (rev_more) begin
          i_nxt     = i_r + 1'b1;
          j_nxt     = j_r - 1'b1;
          state_nxt = S_REV_RD;
        end else begin
          res_status_nxt = bssr_pkg::STAT_OK;
          state_nxt      = S_RESULT;
        end
      end

      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = res_status_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      i_r          <= '0;
      j_r          <= '0;
      res_status_r <= bssr_pkg::STAT_OK;
    end else begin
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  `BSSR_ASSERT(a_idle_no_write, clk, rst_n, (state_r == S_IDLE) |-> !cmd.wr_en)
  `BSSR_ASSERT(a_sort_j_bound, clk, rst_n, (state_r == S_SORT_STEP) |-> (j_r <= i_r))
  `BSSR_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)

endmodule

/* rtl/core/bounded_stack_sort_reverse.sv */
// top level of the bounded stack with show, sort and reverse
//
//   channel  ports                      beat
//   in       in_valid / in_ready        one operation: kind, push_value
//   out      out_valid / out_ready      one result: status, data, last, fill_count
//   cfg      cfg_valid / cfg_ready      capacity, always ready
//
// an empty pop, show, sort or reverse, and a sort or reverse of one entry, go straight
// to the result. push writes as it loads its result; pop reads the top entry, then
// returns it; show returns entries from the top down; reverse reads a pair, then
// writes each end; sort moves each entry down past smaller ones. reset is synchronous,
// empties the stack and returns capacity to 5. a stalled out beat holds the block.
`timescale 1ns / 1ps

module bounded_stack_sort_reverse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bssr_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bssr_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bssr_pkg::CAP_W-1:0] cfg_data
);

  bssr_pkg::cmd_t  cmd;
  bssr_pkg::stat_t stat;

  bssr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_item.kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  bssr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
